// ----- src/ballistic_launch_velocity_core_macros.svh -----
// Assertion macros shared by the checker.
`ifndef BALLISTIC_LAUNCH_VELOCITY_CORE_MACROS_SVH
`define BALLISTIC_LAUNCH_VELOCITY_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BLV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BLV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/blv_pkg.sv -----
// Types, constants and per-stage step functions for the launch velocity core.
`timescale 1ns / 1ps
`default_nettype none
package blv_pkg;

    localparam int unsigned FIELD_W = 32;
    localparam int unsigned GRAV_W  = 24;

    localparam logic [GRAV_W-1:0]  GRAVITY_RESET = 24'd250880;
    localparam logic signed [31:0] MIN_CLEAR     = 32'sd2560;
    localparam logic [45:0]        MIN_TIME      = 46'd3277;

    // steps of each iterative unit, one per pipeline stage
    localparam int unsigned SQV_STEPS  = 29;  // sqrt of 2*g*rise_up
    localparam int unsigned TUP_STEPS  = 45;  // vz<<16 / g
    localparam int unsigned QDIV_STEPS = 66;  // 2*rise_dn<<32 / g
    localparam int unsigned SQQ_STEPS  = 32;  // sqrt of q
    localparam int unsigned P1_STAGES  = QDIV_STEPS + SQQ_STEPS;
    localparam int unsigned HDIV_STEPS = 49;  // |d|<<16 / T

    typedef struct packed {
        logic [57:0] rad;
        logic [29:0] rem;
        logic [28:0] root;
    } sq29_t;

    typedef struct packed {
        logic [63:0] rad;
        logic [32:0] rem;
        logic [31:0] root;
    } sq32_t;

    typedef struct packed {
        logic [44:0] num;
        logic [23:0] rem;
        logic [44:0] quo;
    } dv45_t;

    typedef struct packed {
        logic [65:0] num;
        logic [23:0] rem;
        logic [65:0] quo;
    } dv66_t;

    typedef struct packed {
        logic [48:0] num;
        logic [45:0] rem;
        logic [48:0] quo;
    } dv49_t;

    // front half: two chains (root then divider, divider then root) run side by side
    typedef struct packed {
        logic [GRAV_W-1:0] g;
        logic [32:0]       dx;
        logic [32:0]       dy;
        sq29_t             sv;
        dv45_t             tu;
        dv66_t             qd;
        sq32_t             sq;
    } p1_t;

    // back half: horizontal dividers
    typedef struct packed {
        logic [45:0] t;
        logic [28:0] vz;
        logic        xneg;
        logic        yneg;
        dv49_t       xd;
        dv49_t       yd;
    } p3_t;

    // partial remainder stays below 2*root, so its top bit is clear until the last step
    function automatic sq29_t sq29_step(input sq29_t s);
        logic [30:0] rem2;
        logic [30:0] trial;
        sq29_t       r;
        rem2  = {s.rem[28:0], s.rad[57:56]};
        trial = {s.root, 2'b01};
        r.rad = {s.rad[55:0], 2'b00};
        if (rem2 >= trial)
        begin
            r.rem  = 30'(rem2 - trial);
            r.root = {s.root[27:0], 1'b1};
        end
        else
        begin
            r.rem  = rem2[29:0];
            r.root = {s.root[27:0], 1'b0};
        end
        return r;
    endfunction

    function automatic sq32_t sq32_step(input sq32_t s);
        logic [33:0] rem2;
        logic [33:0] trial;
        sq32_t       r;
        rem2  = {s.rem[31:0], s.rad[63:62]};
        trial = {s.root, 2'b01};
        r.rad = {s.rad[61:0], 2'b00};
        if (rem2 >= trial)
        begin
            r.rem  = 33'(rem2 - trial);
            r.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            r.rem  = rem2[32:0];
            r.root = {s.root[30:0], 1'b0};
        end
        return r;
    endfunction

    function automatic dv45_t dv45_step(input dv45_t s, input logic [23:0] d);
        logic [24:0] rem2;
        dv45_t       r;
        rem2  = {s.rem, s.num[44]};
        r.num = {s.num[43:0], 1'b0};
        if (rem2 >= {1'b0, d})
        begin
            r.rem = 24'(rem2 - {1'b0, d});
            r.quo = {s.quo[43:0], 1'b1};
        end
        else
        begin
            r.rem = rem2[23:0];
            r.quo = {s.quo[43:0], 1'b0};
        end
        return r;
    endfunction

    function automatic dv66_t dv66_step(input dv66_t s, input logic [23:0] d);
        logic [24:0] rem2;
        dv66_t       r;
        rem2  = {s.rem, s.num[65]};
        r.num = {s.num[64:0], 1'b0};
        if (rem2 >= {1'b0, d})
        begin
            r.rem = 24'(rem2 - {1'b0, d});
            r.quo = {s.quo[64:0], 1'b1};
        end
        else
        begin
            r.rem = rem2[23:0];
            r.quo = {s.quo[64:0], 1'b0};
        end
        return r;
    endfunction

    function automatic dv49_t dv49_step(input dv49_t s, input logic [45:0] d);
        logic [46:0] rem2;
        dv49_t       r;
        rem2  = {s.rem, s.num[48]};
        r.num = {s.num[47:0], 1'b0};
        if (rem2 >= {1'b0, d})
        begin
            r.rem = 46'(rem2 - {1'b0, d});
            r.quo = {s.quo[47:0], 1'b1};
        end
        else
        begin
            r.rem = rem2[45:0];
            r.quo = {s.quo[47:0], 1'b0};
        end
        return r;
    endfunction

    // apply sign to a magnitude and clamp to int32
    function automatic logic [31:0] sat_signed(input logic neg, input logic [48:0] mag);
        logic [31:0] r;
        if (neg)
        begin
            if (mag > 49'h0_8000_0000)
                r = 32'h8000_0000;
            else
                r = 32'(-mag);
        end
        else
        begin
            if (mag > 49'h0_7FFF_FFFF)
                r = 32'h7FFF_FFFF;
            else
                r = mag[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/ballistic_launch_velocity_core.sv -----
// Ballistic launch velocity core: fully pipelined, one word per unstalled cycle.
`timescale 1ns / 1ps
`default_nettype none
// Takes one word per clock unless stalled; one result word per input, in order.
// The path from input accept to output valid runs through three front stages
// (deltas, rise heights, the 2*g*rise multiply), 98 stages in which the vertical
// square root plus rise-time divider run beside the fall-time divider plus square
// root (one quotient or root bit per stage), one stage for flight time and signs,
// 49 stages of horizontal divider (one bit per stage) and the output register.
// The whole pipe advances whenever the output register is empty or being taken;
// in_ready drops only while a finished word sits unclaimed at the output.
// Gravity is written through the cfg channel (always ready); the user must do so
// only while idle; the block does not enforce it. A zero value behaves as one.
module ballistic_launch_velocity_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [blv_pkg::GRAV_W-1:0]   cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [31:0]           start_x,
    input  wire logic signed [31:0]           start_y,
    input  wire logic signed [31:0]           start_z,
    input  wire logic signed [31:0]           target_x,
    input  wire logic signed [31:0]           target_y,
    input  wire logic signed [31:0]           target_z,
    input  wire logic signed [31:0]           extra_apex_height,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [31:0]                vel_x,
    output logic signed [31:0]                vel_y,
    output logic signed [31:0]                vel_z
);
    import blv_pkg::*;

    logic              en;
    logic [GRAV_W-1:0] gravity_reg;

    // stage A
    logic              a_valid_reg;
    logic [32:0]       a_dz_reg;
    logic [30:0]       a_clear_reg;
    logic [32:0]       a_dx_reg;
    logic [32:0]       a_dy_reg;
    logic [GRAV_W-1:0] a_g_reg;
    logic [32:0]       a_dz_next;
    logic signed [31:0] a_clear_full;

    // stage B
    logic              b_valid_reg;
    logic [32:0]       b_rise_up_reg;
    logic [32:0]       b_rise_dn_reg;
    logic [32:0]       b_dx_reg;
    logic [32:0]       b_dy_reg;
    logic [GRAV_W-1:0] b_g_reg;
    logic [32:0]       b_up_next;
    logic [32:0]       b_dn_next;
    logic [32:0]       b_neg_dz;

    // front half pipe
    logic              p1_valid_reg [0:P1_STAGES];
    p1_t               p1_reg       [0:P1_STAGES];
    p1_t               p1_next      [0:P1_STAGES-1];
    p1_t               p1_load;

    // back half pipe
    logic              p3_valid_reg [0:HDIV_STEPS];
    p3_t               p3_reg       [0:HDIV_STEPS];
    p3_t               p3_next      [0:HDIV_STEPS-1];
    p3_t               p3_load;
    logic [45:0]       t_sum;
    logic [32:0]       mag_x;
    logic [32:0]       mag_y;

    logic              out_valid_reg;
    logic [31:0]       vel_x_reg;
    logic [31:0]       vel_y_reg;
    logic [31:0]       vel_z_reg;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gravity_reg <= GRAVITY_RESET;
        else if (cfg_valid)
            gravity_reg <= cfg_data;
    end

    // ---- stage A: deltas and clearance
    assign a_dz_next    = {target_z[31], target_z} - {start_z[31], start_z};
    assign a_clear_full = (extra_apex_height > MIN_CLEAR) ? extra_apex_height : MIN_CLEAR;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dz_reg    <= a_dz_next;
            a_clear_reg <= a_clear_full[30:0];
            a_dx_reg    <= {target_x[31], target_x} - {start_x[31], start_x};
            a_dy_reg    <= {target_y[31], target_y} - {start_y[31], start_y};
            a_g_reg     <= (gravity_reg == '0) ? GRAV_W'(1) : gravity_reg;
        end
    end

    // ---- stage B: rise above each endpoint
    assign b_neg_dz  = 33'(-a_dz_reg);
    assign b_up_next = (a_dz_reg[32] ? 33'd0 : a_dz_reg) + {2'b00, a_clear_reg};
    assign b_dn_next = (a_dz_reg[32] ? b_neg_dz : 33'd0) + {2'b00, a_clear_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_rise_up_reg <= b_up_next;
            b_rise_dn_reg <= b_dn_next;
            b_dx_reg      <= a_dx_reg;
            b_dy_reg      <= a_dy_reg;
            b_g_reg       <= a_g_reg;
        end
    end

    // ---- stage C: radicand 2*g*rise_up, numerator 2*rise_dn<<32
    always_comb
    begin
        p1_load         = '0;
        p1_load.g       = b_g_reg;
        p1_load.dx      = b_dx_reg;
        p1_load.dy      = b_dy_reg;
        p1_load.sv.rad  = {57'({24'd0, b_g_reg} * {24'd0, b_rise_up_reg}), 1'b0};
        p1_load.qd.num  = {b_rise_dn_reg, 1'b0, 32'd0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p1_reg[0] <= p1_load;
    end

    // ---- front half: one bit per stage in each unit
    genvar k;
    generate
        for (k = 0; k < P1_STAGES; k++)
        begin : g_p1
            always_comb
            begin
                p1_next[k] = p1_reg[k];
                if (k < SQV_STEPS)
                begin
                    p1_next[k].sv = sq29_step(p1_reg[k].sv);
                    if (k == SQV_STEPS - 1)
                    begin
                        p1_next[k].tu.num = {p1_next[k].sv.root, 16'd0};
                        p1_next[k].tu.rem = '0;
                        p1_next[k].tu.quo = '0;
                    end
                end
                else if (k < SQV_STEPS + TUP_STEPS)
                begin
                    p1_next[k].tu = dv45_step(p1_reg[k].tu, p1_reg[k].g);
                end
                if (k < QDIV_STEPS)
                begin
                    p1_next[k].qd = dv66_step(p1_reg[k].qd, p1_reg[k].g);
                    if (k == QDIV_STEPS - 1)
                    begin
                        // quotient at or above 2^63 clamps to 2^63
                        p1_next[k].sq.rad  = (p1_next[k].qd.quo[65:63] != 3'd0) ?
                                             {1'b1, 63'd0} :
                                             {1'b0, p1_next[k].qd.quo[62:0]};
                        p1_next[k].sq.rem  = '0;
                        p1_next[k].sq.root = '0;
                    end
                end
                else
                begin
                    p1_next[k].sq = sq32_step(p1_reg[k].sq);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    p1_reg[k+1] <= p1_next[k];
            end
        end
    endgenerate

    // ---- flight time, magnitudes and signs
    assign t_sum = {1'b0, p1_reg[P1_STAGES].tu.quo} + {14'd0, p1_reg[P1_STAGES].sq.root};
    assign mag_x = p1_reg[P1_STAGES].dx[32] ? 33'(-p1_reg[P1_STAGES].dx) : p1_reg[P1_STAGES].dx;
    assign mag_y = p1_reg[P1_STAGES].dy[32] ? 33'(-p1_reg[P1_STAGES].dy) : p1_reg[P1_STAGES].dy;

    always_comb
    begin
        p3_load        = '0;
        p3_load.t      = (t_sum < MIN_TIME) ? MIN_TIME : t_sum;
        p3_load.vz     = p1_reg[P1_STAGES].sv.root;
        p3_load.xneg   = p1_reg[P1_STAGES].dx[32];
        p3_load.yneg   = p1_reg[P1_STAGES].dy[32];
        p3_load.xd.num = {mag_x, 16'd0};
        p3_load.yd.num = {mag_y, 16'd0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p3_reg[0] <= p3_load;
    end

    // ---- back half: horizontal dividers
    generate
        for (k = 0; k < HDIV_STEPS; k++)
        begin : g_p3
            always_comb
            begin
                p3_next[k]    = p3_reg[k];
                p3_next[k].xd = dv49_step(p3_reg[k].xd, p3_reg[k].t);
                p3_next[k].yd = dv49_step(p3_reg[k].yd, p3_reg[k].t);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    p3_reg[k+1] <= p3_next[k];
            end
        end
    endgenerate

    // ---- valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            for (int i = 0; i <= P1_STAGES; i++)
                p1_valid_reg[i] <= 1'b0;
            for (int i = 0; i <= HDIV_STEPS; i++)
                p3_valid_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg     <= in_valid;
            b_valid_reg     <= a_valid_reg;
            p1_valid_reg[0] <= b_valid_reg;
            for (int i = 1; i <= P1_STAGES; i++)
                p1_valid_reg[i] <= p1_valid_reg[i-1];
            p3_valid_reg[0] <= p1_valid_reg[P1_STAGES];
            for (int i = 1; i <= HDIV_STEPS; i++)
                p3_valid_reg[i] <= p3_valid_reg[i-1];
            out_valid_reg <= p3_valid_reg[HDIV_STEPS];
        end
    end

    // ---- output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vel_x_reg <= sat_signed(p3_reg[HDIV_STEPS].xneg, p3_reg[HDIV_STEPS].xd.quo);
            vel_y_reg <= sat_signed(p3_reg[HDIV_STEPS].yneg, p3_reg[HDIV_STEPS].yd.quo);
            vel_z_reg <= {3'd0, p3_reg[HDIV_STEPS].vz};
        end
    end

    assign out_valid = out_valid_reg;
    assign vel_x     = vel_x_reg;
    assign vel_y     = vel_y_reg;
    assign vel_z     = vel_z_reg;

endmodule
`default_nettype wire

// ----- src/blv_checker.sv -----
// Port-level checker for the launch velocity core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "ballistic_launch_velocity_core_macros.svh"
module blv_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [31:0] vel_x,
    input wire logic signed [31:0] vel_y,
    input wire logic signed [31:0] vel_z
);

    // a waiting word holds its value
    `BLV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(vel_x) && $stable(vel_y) && $stable(vel_z),
        "output word changed while stalled")

    // the pipe only stops for an unclaimed output word
    `BLV_ASSERT_NOW(a_ready_free, !out_valid || out_ready, in_ready,
        "input stalled with output free")

    `BLV_ASSERT_NOW(a_ready_stall, out_valid && !out_ready, !in_ready,
        "input taken while output stalled")

    `BLV_ASSERT_NOW(a_vz_sign, out_valid, !vel_z[31],
        "vertical speed negative")

endmodule

bind ballistic_launch_velocity_core blv_checker u_blv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .vel_z     (vel_z)
);
`default_nettype wire
